// ===== design/vpy_pkg.sv =====
// shared types, constants and the cos^2 degree table for the pitch/yaw block
// no dependencies; the table is built at elaboration from integer power series
package vpy_pkg;

    localparam int COORD_W     = 16;
    localparam int SQ_W        = 32;
    localparam int DEG_W       = 9;
    localparam int G_W         = 7;
    localparam int FRAC_BITS   = 160;
    localparam int FX_W        = 192;
    localparam int LIMB_W      = 32;
    localparam int C_LIMBS     = FRAC_BITS / LIMB_W;
    localparam int TAB_DEPTH   = 90;
    localparam int LEVELS      = 7;
    localparam int STEP_LAT    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int SERIES_TERMS = 20;

    localparam logic [G_W-1:0]   MAX_DEG = 7'd89;
    localparam logic [DEG_W-1:0] DEG_0   = 9'd0;
    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_135 = 9'd135;
    localparam logic [DEG_W-1:0] DEG_179 = 9'd179;
    localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

    typedef struct packed {
        logic signed [COORD_W-1:0] vec_x;
        logic signed [COORD_W-1:0] vec_y;
        logic signed [COORD_W-1:0] vec_z;
    } t_vec_in;

    typedef struct packed {
        logic [DEG_W-1:0] pitch_deg;
        logic [DEG_W-1:0] yaw_deg;
    } t_res_out;

    typedef struct packed {
        logic vert;
        logic xzero;
        logic xneg;
        logic yzero;
        logic yneg;
        logic diag;
        logic zpos;
        logic zneg;
    } t_cls;

    typedef struct packed {
        logic [SQ_W-1:0] t_y;
        logic [SQ_W-1:0] n_y;
        logic [SQ_W-1:0] t_p;
        logic [SQ_W-1:0] n_p;
        t_cls            cls;
    } t_work;

    typedef logic [FRAC_BITS-1:0] t_cos_tab [0:TAB_DEPTH-1];

    function automatic logic [FX_W-1:0] fx_mul(input logic [FX_W-1:0] a,
                                               input logic [FX_W-1:0] b);
        logic [2*FX_W-1:0] p;
        p = {{FX_W{1'b0}}, a} * {{FX_W{1'b0}}, b};
        return p[FX_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

    function automatic logic [FX_W-1:0] fx_mul_small(input logic [FX_W-1:0] a,
                                                     input logic [31:0] m);
        logic [FX_W+31:0] p;
        p = {32'b0, a} * {{FX_W{1'b0}}, m};
        return p[FX_W-1:0];
    endfunction

    // restoring long division by a small integer
    function automatic logic [FX_W-1:0] fx_div_small(input logic [FX_W-1:0] a,
                                                     input logic [31:0] d);
        logic [FX_W-1:0] q;
        logic [63:0]     rem;
        q   = '0;
        rem = '0;
        for (int i = FX_W - 1; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= {32'b0, d}) begin
                rem  = rem - {32'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_cos_tab cos_sq_table();
        t_cos_tab        tab;
        logic [FX_W-1:0] pi_v, one, x, x2, cp, cn, sp, sn, t, u, c, s, sq;
        pi_v = {32'd3, 32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
                32'hA4093822};
        one  = {32'd1, {FRAC_BITS{1'b0}}};
        tab[0] = '0;
        for (int d = 1; d <= 45; d++) begin
            x  = fx_div_small(fx_mul_small(pi_v, 32'(d)), 32'd180);
            x2 = fx_mul(x, x);
            cp = one;
            cn = '0;
            t  = one;
            sp = x;
            sn = '0;
            u  = x;
            for (int k = 1; k <= SERIES_TERMS; k++) begin
                t = fx_div_small(fx_mul(t, x2), 32'((2 * k - 1) * (2 * k)));
                u = fx_div_small(fx_mul(u, x2), 32'((2 * k) * (2 * k + 1)));
                if ((k % 2) == 1) begin
                    cn = cn + t;
                    sn = sn + u;
                end else begin
                    cp = cp + t;
                    sp = sp + u;
                end
            end
            c  = cp - cn;
            s  = sp - sn;
            sq = fx_mul(c, c);
            tab[d] = sq[FRAC_BITS-1:0];
            sq = fx_mul(s, s);
            tab[90 - d] = sq[FRAC_BITS-1:0];
        end
        tab[30] = {32'hC0000000, 128'b0};
        tab[45] = {32'h80000000, 128'b0};
        tab[60] = {32'h40000000, 128'b0};
        return tab;
    endfunction

    localparam t_cos_tab COS_SQ = cos_sq_table();

endpackage

// ===== design/vpy_queue.sv =====
// small register queue used between front and back and at the result side
// no dependencies
module vpy_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= wrap_inc(r_wp);
            if (i_rd) r_rp <= wrap_inc(r_rp);
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
endmodule

// ===== design/vpy_front.sv =====
// front part: takes vectors, squares the components and classifies them
// depends on vpy_pkg
module vpy_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_acc,
    input  vpy_pkg::t_vec_in i_vec,
    output logic            o_vld,
    output vpy_pkg::t_work  o_work
);
    logic                          r_v1, r_v2;
    vpy_pkg::t_vec_in              r_vec1;
    logic [vpy_pkg::COORD_W-1:0]   ax, ay, az;
    logic [vpy_pkg::SQ_W-1:0]      r_sx, r_sy, r_sz;
    vpy_pkg::t_cls                 n_cls, r_cls2;
    logic [vpy_pkg::SQ_W-1:0]      sxy;

    always_comb begin
        ax = r_vec1.vec_x[vpy_pkg::COORD_W-1] ? vpy_pkg::COORD_W'(-r_vec1.vec_x)
                                              : vpy_pkg::COORD_W'(r_vec1.vec_x);
        ay = r_vec1.vec_y[vpy_pkg::COORD_W-1] ? vpy_pkg::COORD_W'(-r_vec1.vec_y)
                                              : vpy_pkg::COORD_W'(r_vec1.vec_y);
        az = r_vec1.vec_z[vpy_pkg::COORD_W-1] ? vpy_pkg::COORD_W'(-r_vec1.vec_z)
                                              : vpy_pkg::COORD_W'(r_vec1.vec_z);
        n_cls.xzero = (r_vec1.vec_x == '0);
        n_cls.yzero = (r_vec1.vec_y == '0);
        n_cls.vert  = n_cls.xzero && n_cls.yzero;
        n_cls.xneg  = r_vec1.vec_x[vpy_pkg::COORD_W-1];
        n_cls.yneg  = r_vec1.vec_y[vpy_pkg::COORD_W-1];
        n_cls.zneg  = r_vec1.vec_z[vpy_pkg::COORD_W-1];
        n_cls.zpos  = !n_cls.zneg && (r_vec1.vec_z != '0);
        n_cls.diag  = (ax == ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec1 <= i_vec;
            r_sx   <= {{vpy_pkg::COORD_W{1'b0}}, ax} * {{vpy_pkg::COORD_W{1'b0}}, ax};
            r_sy   <= {{vpy_pkg::COORD_W{1'b0}}, ay} * {{vpy_pkg::COORD_W{1'b0}}, ay};
            r_sz   <= {{vpy_pkg::COORD_W{1'b0}}, az} * {{vpy_pkg::COORD_W{1'b0}}, az};
            r_cls2 <= n_cls;
        end
    end

    assign sxy          = r_sx + r_sy;
    assign o_vld        = r_v2;
    assign o_work.t_y   = sxy;
    assign o_work.n_y   = r_sx;
    assign o_work.t_p   = sxy + r_sz;
    assign o_work.n_p   = sxy;
    assign o_work.cls   = r_cls2;
endmodule

// ===== design/vpy_deg_step.sv =====
// one binary search step: tries one degree bit against t * cos^2(d) >= n
// depends on vpy_pkg for the cos^2 table
module vpy_deg_step #(
    parameter int BIT = 0
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [vpy_pkg::SQ_W-1:0]     i_t,
    input  logic [vpy_pkg::SQ_W-1:0]     i_n,
    input  logic [vpy_pkg::G_W-1:0]      i_g,
    output logic [vpy_pkg::SQ_W-1:0]     o_t,
    output logic [vpy_pkg::SQ_W-1:0]     o_n,
    output logic [vpy_pkg::G_W-1:0]      o_g
);
    localparam int CL = vpy_pkg::C_LIMBS;
    localparam int LW = vpy_pkg::LIMB_W;
    localparam int FW = vpy_pkg::FX_W;
    localparam int FB = vpy_pkg::FRAC_BITS;

    logic [vpy_pkg::G_W-1:0]       cand, idx;
    logic                          ok;
    logic [FB-1:0]                 r_c0;
    logic [vpy_pkg::SQ_W-1:0]      r_t0, r_n0, r_t1, r_n1, r_t2, r_n2, r_t3, r_n3;
    logic [vpy_pkg::G_W-1:0]       r_g0, r_g1, r_g2, r_g3;
    logic [vpy_pkg::G_W-1:0]       r_cand0, r_cand1, r_cand2;
    logic                          r_ok0, r_ok1, r_ok2;
    logic [2*LW-1:0]               r_pp [0:CL-1];
    logic [FW-1:0]                 even, odd, r_row;
    logic                          pass;

    assign cand = i_g | vpy_pkg::G_W'(1 << BIT);
    assign ok   = (cand <= vpy_pkg::MAX_DEG);
    assign idx  = ok ? cand : '0;

    always_comb begin
        even = '0;
        odd  = '0;
        for (int j = 0; j < CL; j++) begin
            if ((j % 2) == 0) even[j*LW +: 2*LW] = r_pp[j];
            else              odd[j*LW +: 2*LW]  = r_pp[j];
        end
    end

    assign pass = r_ok2 && (r_row[FW-1:FB] >= r_n2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0    <= vpy_pkg::COS_SQ[idx];
            r_t0    <= i_t;
            r_n0    <= i_n;
            r_g0    <= i_g;
            r_cand0 <= cand;
            r_ok0   <= ok;
            for (int j = 0; j < CL; j++)
                r_pp[j] <= {{LW{1'b0}}, r_t0} * {{LW{1'b0}}, r_c0[j*LW +: LW]};
            r_t1    <= r_t0;
            r_n1    <= r_n0;
            r_g1    <= r_g0;
            r_cand1 <= r_cand0;
            r_ok1   <= r_ok0;
            r_row   <= even + odd;
            r_t2    <= r_t1;
            r_n2    <= r_n1;
            r_g2    <= r_g1;
            r_cand2 <= r_cand1;
            r_ok2   <= r_ok1;
            r_g3    <= pass ? r_cand2 : r_g2;
            r_t3    <= r_t2;
            r_n3    <= r_n2;
        end
    end

    assign o_t = r_t3;
    assign o_n = r_n3;
    assign o_g = r_g3;
endmodule

// ===== design/vpy_back.sv =====
// back part: two binary searches over whole degrees, then angle assembly
// depends on vpy_pkg and vpy_deg_step
module vpy_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_have,
    input  vpy_pkg::t_work    i_work,
    output logic              o_take,
    output logic              o_push,
    output vpy_pkg::t_res_out o_res
);
    localparam int LV  = vpy_pkg::LEVELS;
    localparam int LAT = vpy_pkg::LEVELS * vpy_pkg::STEP_LAT;

    logic [vpy_pkg::SQ_W-1:0] w_ty [0:LV];
    logic [vpy_pkg::SQ_W-1:0] w_ny [0:LV];
    logic [vpy_pkg::SQ_W-1:0] w_tp [0:LV];
    logic [vpy_pkg::SQ_W-1:0] w_np [0:LV];
    logic [vpy_pkg::G_W-1:0]  w_gy [0:LV];
    logic [vpy_pkg::G_W-1:0]  w_gp [0:LV];
    logic [LAT-1:0]           r_vld;
    vpy_pkg::t_cls            r_cls [0:LAT-1];
    vpy_pkg::t_cls            cls;
    logic [vpy_pkg::DEG_W-1:0] gy, gp, th;

    assign o_take  = i_adv && i_have;
    assign w_ty[0] = i_work.t_y;
    assign w_ny[0] = i_work.n_y;
    assign w_tp[0] = i_work.t_p;
    assign w_np[0] = i_work.n_p;
    assign w_gy[0] = '0;
    assign w_gp[0] = '0;

    for (genvar k = 0; k < LV; k++) begin : g_lvl
        vpy_deg_step #(.BIT(LV - 1 - k)) u_yaw (
            .i_clk (i_clk),
            .i_en  (i_adv),
            .i_t   (w_ty[k]),
            .i_n   (w_ny[k]),
            .i_g   (w_gy[k]),
            .o_t   (w_ty[k+1]),
            .o_n   (w_ny[k+1]),
            .o_g   (w_gy[k+1])
        );
        vpy_deg_step #(.BIT(LV - 1 - k)) u_pitch (
            .i_clk (i_clk),
            .i_en  (i_adv),
            .i_t   (w_tp[k]),
            .i_n   (w_np[k]),
            .i_g   (w_gp[k]),
            .o_t   (w_tp[k+1]),
            .o_n   (w_np[k+1]),
            .o_g   (w_gp[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[LAT-2:0], o_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cls[0] <= i_work.cls;
            for (int i = 1; i < LAT; i++) r_cls[i] <= r_cls[i-1];
        end
    end

    always_comb begin
        cls = r_cls[LAT-1];
        gy  = {2'b0, w_gy[LV]};
        gp  = {2'b0, w_gp[LV]};
        if (cls.xzero)      th = vpy_pkg::DEG_90;
        else if (!cls.xneg) th = gy;
        else if (cls.yzero) th = vpy_pkg::DEG_180;
        else if (cls.diag)  th = vpy_pkg::DEG_135;
        else                th = vpy_pkg::DEG_179 - gy;
        if (cls.vert) begin
            o_res.yaw_deg   = vpy_pkg::DEG_0;
            o_res.pitch_deg = cls.zpos ? vpy_pkg::DEG_90 : vpy_pkg::DEG_270;
        end else begin
            o_res.yaw_deg   = (!cls.yneg || th == vpy_pkg::DEG_0) ? th
                                                                 : vpy_pkg::DEG_360 - th;
            o_res.pitch_deg = (!cls.zneg || gp == vpy_pkg::DEG_0) ? gp
                                                                 : vpy_pkg::DEG_360 - gp;
        end
    end

    assign o_push = i_adv && r_vld[LAT-1];
endmodule

// ===== design/vector_to_pitch_yaw_degrees.sv =====
// top level: direction vector to pitch and yaw in whole degrees
// depends on vpy_pkg, vpy_front, vpy_queue, vpy_back
//
// usage:
//   input channel: present a vector on i_vec and raise push; the beat is
//   taken at a clock edge where push is high and full is low.
//   result channel: while empty is low, o_res holds the oldest result;
//   raise pop to take it. one result per vector, in order.
//   throughput: one vector per cycle, sustained, while the receiver pops.
//   path: the input beat edge loads the first of two front stages; the beat then
//   passes one queue stage, 28 search stages in seven degree steps per angle
//   and one result queue stage before empty goes low.
//   the whole-degree search is a binary search over a 90-entry cos^2 table
//   with 160 fraction bits; each step is five 32x32 partial products.
//   reset (synchronous, active low) empties both queues and all stages.
//   when the receiver stalls, the result queue fills and the back stages
//   freeze; the queue between front and back then fills and full rises.
module vector_to_pitch_yaw_degrees #(
    parameter int QUEUE_DEPTH = vpy_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  vpy_pkg::t_vec_in  i_vec,
    input  logic              pop,
    output logic              empty,
    output vpy_pkg::t_res_out o_res
);
    logic              adv_f, adv_b;
    logic              mid_full, mid_empty, out_full;
    logic              f_vld, b_take, b_push;
    vpy_pkg::t_work    f_work, mid_work;
    vpy_pkg::t_res_out b_res;

    assign adv_f = !mid_full;
    assign adv_b = !out_full;
    assign full  = !adv_f;

    vpy_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_f),
        .i_acc   (push && adv_f),
        .i_vec   (i_vec),
        .o_vld   (f_vld),
        .o_work  (f_work)
    );

    vpy_queue #(.W($bits(vpy_pkg::t_work)), .DEPTH(QUEUE_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_vld && adv_f),
        .i_data  (f_work),
        .o_full  (mid_full),
        .i_rd    (b_take),
        .o_empty (mid_empty),
        .o_data  (mid_work)
    );

    vpy_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv_b),
        .i_have  (!mid_empty),
        .i_work  (mid_work),
        .o_take  (b_take),
        .o_push  (b_push),
        .o_res   (b_res)
    );

    vpy_queue #(.W($bits(vpy_pkg::t_res_out)), .DEPTH(QUEUE_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (b_push),
        .i_data  (b_res),
        .o_full  (out_full),
        .i_rd    (pop && !empty),
        .o_empty (empty),
        .o_data  (o_res)
    );
endmodule

// ===== design/vpy_checker.sv =====
// port-level checks for the pitch/yaw block, bound to the top level
// depends on vpy_pkg and vector_to_pitch_yaw_degrees
module vpy_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input vpy_pkg::t_res_out o_res
);
    logic [6:0] r_cnt;
    logic       acc_in, acc_out;

    assign acc_in  = push && !full;
    assign acc_out = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({acc_in, acc_out})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_res))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.pitch_deg < vpy_pkg::DEG_360) &&
                   (o_res.yaw_deg < vpy_pkg::DEG_360))
        else $error("angle out of range");

    a_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_cnt != '0)
        else $error("result beat without an input beat");
endmodule

bind vector_to_pitch_yaw_degrees vpy_checker u_vpy_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .o_res   (o_res)
);
